// File: src/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URI percent decoder
// Holds the command record that travels from the decode front to the result
// back, the error codes, and the character helpers used by the front.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam logic [15:0] PERCENT_UNIT = 16'h0025;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_UTF8   = 2'd2;

    // Count of leading ones of a lead octet; ONES_BAD marks five or more.
    localparam logic [2:0] ONES_BAD = 3'd5;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    // One decoded input item: up to three result units, delivered in order.
    typedef struct packed {
        logic [1:0]       count_m1;
        logic [2:0][15:0] units;
        logic             string_end;
        logic [1:0]       error_code;
    } cmd_t;

    // Decode state, one-hot.
    typedef enum logic [3:0] {
        PH_PLAIN = 4'b0001,
        PH_HI    = 4'b0010,
        PH_LO    = 4'b0100,
        PH_CONT  = 4'b1000
    } phase_t;

    // Hex digit value in the low four bits; bit 4 set when not a hex digit.
    function automatic logic [4:0] hex_value(input logic [15:0] u);
        logic [4:0] v;
        v = 5'h10;
        if (u >= 16'h0030 && u <= 16'h0039) v = {1'b0, u[3:0]};
        else if ((u >= 16'h0041 && u <= 16'h0046) || (u >= 16'h0061 && u <= 16'h0066))
            v = {1'b0, u[3:0] + 4'd9};
        return v;
    endfunction

    // Reserved characters ;/?:@&=+$,# that decodeURI keeps escaped.
    function automatic logic is_reserved(input logic [7:0] o);
        logic r;
        r = 1'b0;
        case (o)
            8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
            8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: src/uri_percent_decoder.sv
`timescale 1ns / 1ps
// Path: the first result of an input transfer passes the command queue and
//   then the output register before it is offered on the master side.
// Throughput: one input transfer per cycle while the queue has room and one
//   result per cycle while m_axis_tready is high; an escape kept as three
//   units or surrogate pair gives three or two results, absorbed by the queue.
// Reset: rst_n clears the decode state, the queue and the output register at
//   once and clears the reserved-escape mode bit; no clearing pass is needed.
// ----------------------------------------------------------------------------
// uri_percent_decoder: streaming percent and UTF-8 decoder for URI text
// Decodes %XX escapes in a stream of UTF-16 code units into code units, with
// optional preservation of reserved characters and a sticky error report.
// ----------------------------------------------------------------------------
module uri_percent_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: the reserved-escape mode bit, written when cfg_wen is high.
    input  logic        cfg_wen,
    input  logic        cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tuser,   // [0] end_marker

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_unit
    output logic [2:0]  m_axis_tuser,   // [0] string_end, [2:1] error_code
    output logic        m_axis_tlast    // last result of the input transfer
);

    // The mode bit that selects decodeURI behavior over the component form.
    logic preserve_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) preserve_reg <= 1'b0;
        else if (cfg_wen) preserve_reg <= cfg_wdata;
    end

    // Front to queue: one command per input transfer that yields results.
    logic          push;
    upd_pkg::cmd_t push_cmd;
    logic          queue_full;

    // Queue to back: show-ahead head command.
    logic          queue_empty;
    logic          pop;
    upd_pkg::cmd_t head;

    logic [15:0]   res_unit;
    logic          res_end;
    logic [1:0]    res_err;

    // The front parses escapes and validates UTF-8 combinationally, so it
    // can take a new code unit every cycle as long as the queue has room.
    upd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .keep_escapes (preserve_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .code_unit    (s_axis_tdata),
        .end_marker   (s_axis_tuser),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    upd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    // The back splits each command into its one to three result transfers.
    upd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (queue_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_unit   (res_unit),
        .string_end (res_end),
        .error_code (res_err),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = res_unit;
    assign m_axis_tuser = {res_err, res_end};

endmodule

// File: src/upd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_front: escape parser and UTF-8 checker
// Accepts one code unit per cycle while the queue has room, tracks the escape
// state and turns each item that yields results into one queue command.
// ----------------------------------------------------------------------------
module upd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          keep_escapes,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   code_unit,
    input  logic          end_marker,
    input  logic          queue_full,
    output logic          push,
    output upd_pkg::cmd_t push_cmd
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  sticky_reg, sticky_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic [2:0]  oct_cnt_reg, oct_cnt_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [15:0] held_hex_reg, held_hex_next;
    logic [7:0]  buf_reg [3];
    logic [7:0]  buf_next [3];

    logic        accept;
    logic [4:0]  dval;
    logic        hex_ok;
    logic [7:0]  octet;
    logic [2:0]  ones;
    logic [7:0]  seq [4];
    logic        cont_bad;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [19:0] cp4_off;
    logic        seq_bad;
    logic [2:0]  cnt_inc;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign dval     = upd_pkg::hex_value(code_unit);
    assign hex_ok   = !dval[4];
    assign octet    = {high_nibble_reg, dval[3:0]};
    assign cnt_inc  = oct_cnt_reg + 3'd1;

    always_comb
    begin
        casez (octet)
            8'b0???????: ones = 3'd0;
            8'b10??????: ones = 3'd1;
            8'b110?????: ones = 3'd2;
            8'b1110????: ones = 3'd3;
            8'b11110???: ones = 3'd4;
            default:     ones = upd_pkg::ONES_BAD;
        endcase
    end

    // The sequence as it stands once the current octet is in place.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (oct_cnt_reg[1:0] == 2'(k) || k == 3) seq[k] = octet;
            else seq[k] = buf_reg[k];
        end
        cont_bad = 1'b0;
        for (int i = 1; i < 4; i++)
        begin
            if (3'(i) < seq_len_reg && seq[i][7:6] != 2'b10) cont_bad = 1'b1;
        end
    end

    assign cp2     = {seq[0][4:0], seq[1][5:0]};
    assign cp3     = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
    assign cp4     = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
    assign cp4_off = 20'(cp4 - 21'h010000);

    always_comb
    begin
        seq_bad = cont_bad;
        if (seq_len_reg == 3'd2)
        begin
            if (cp2 < 11'h080) seq_bad = 1'b1;
        end
        else if (seq_len_reg == 3'd3)
        begin
            if (cp3 < 16'h0800) seq_bad = 1'b1;
            if (cp3 >= 16'hD800 && cp3 <= 16'hDFFF) seq_bad = 1'b1;
        end
        else
        begin
            if (cp4 < 21'h010000 || cp4 > 21'h10FFFF) seq_bad = 1'b1;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        sticky_next      = sticky_reg;
        seq_len_next     = seq_len_reg;
        oct_cnt_next     = oct_cnt_reg;
        high_nibble_next = high_nibble_reg;
        held_hex_next    = held_hex_reg;
        buf_next         = buf_reg;
        push             = 1'b0;
        push_cmd         = '0;

        if (accept)
        begin
            if (end_marker)
            begin
                push                = 1'b1;
                push_cmd.string_end = 1'b1;
                if (sticky_reg != upd_pkg::ERR_NONE) push_cmd.error_code = sticky_reg;
                else if (phase_reg != upd_pkg::PH_PLAIN)
                    push_cmd.error_code = upd_pkg::ERR_ESCAPE;
                phase_next       = upd_pkg::PH_PLAIN;
                sticky_next      = upd_pkg::ERR_NONE;
                seq_len_next     = '0;
                oct_cnt_next     = '0;
                high_nibble_next = '0;
                held_hex_next    = '0;
            end
            else if (sticky_reg == upd_pkg::ERR_NONE)
            begin
                unique case (phase_reg)
                    upd_pkg::PH_PLAIN:
                    begin
                        if (code_unit != upd_pkg::PERCENT_UNIT)
                        begin
                            push              = 1'b1;
                            push_cmd.units[0] = code_unit;
                        end
                        else
                        begin
                            oct_cnt_next = '0;
                            seq_len_next = '0;
                            phase_next   = upd_pkg::PH_HI;
                        end
                    end
                    upd_pkg::PH_HI:
                    begin
                        if (!hex_ok)
                        begin
                            sticky_next = upd_pkg::ERR_ESCAPE;
                            phase_next  = upd_pkg::PH_PLAIN;
                        end
                        else
                        begin
                            high_nibble_next = dval[3:0];
                            held_hex_next    = code_unit;
                            phase_next       = upd_pkg::PH_LO;
                        end
                    end
                    upd_pkg::PH_LO:
                    begin
                        if (!hex_ok)
                        begin
                            sticky_next = upd_pkg::ERR_ESCAPE;
                            phase_next  = upd_pkg::PH_PLAIN;
                        end
                        else if (oct_cnt_reg == 3'd0)
                        begin
                            if (ones == 3'd0)
                            begin
                                phase_next = upd_pkg::PH_PLAIN;
                                push       = 1'b1;
                                if (keep_escapes && upd_pkg::is_reserved(octet))
                                begin
                                    push_cmd.count_m1 = 2'd2;
                                    push_cmd.units[0] = upd_pkg::PERCENT_UNIT;
                                    push_cmd.units[1] = held_hex_reg;
                                    push_cmd.units[2] = code_unit;
                                end
                                else
                                begin
                                    push_cmd.units[0] = {8'h00, octet};
                                end
                            end
                            else if (ones == 3'd1 || ones == upd_pkg::ONES_BAD)
                            begin
                                sticky_next = upd_pkg::ERR_UTF8;
                                phase_next  = upd_pkg::PH_PLAIN;
                            end
                            else
                            begin
                                buf_next[0]  = octet;
                                seq_len_next = ones;
                                oct_cnt_next = 3'd1;
                                phase_next   = upd_pkg::PH_CONT;
                            end
                        end
                        else
                        begin
                            if (oct_cnt_reg[1:0] != 2'd3) buf_next[oct_cnt_reg[1:0]] = octet;
                            oct_cnt_next = cnt_inc;
                            if (cnt_inc >= seq_len_reg)
                            begin
                                phase_next = upd_pkg::PH_PLAIN;
                                if (seq_bad)
                                begin
                                    sticky_next = upd_pkg::ERR_UTF8;
                                end
                                else
                                begin
                                    push = 1'b1;
                                    if (seq_len_reg == 3'd2)
                                        push_cmd.units[0] = {5'd0, cp2};
                                    else if (seq_len_reg == 3'd3)
                                        push_cmd.units[0] = cp3;
                                    else
                                    begin
                                        push_cmd.count_m1 = 2'd1;
                                        push_cmd.units[0] =
                                            {upd_pkg::HI_SURR_TAG, cp4_off[19:10]};
                                        push_cmd.units[1] =
                                            {upd_pkg::LO_SURR_TAG, cp4_off[9:0]};
                                    end
                                end
                            end
                            else
                            begin
                                phase_next = upd_pkg::PH_CONT;
                            end
                        end
                    end
                    upd_pkg::PH_CONT:
                    begin
                        if (code_unit != upd_pkg::PERCENT_UNIT)
                        begin
                            sticky_next = upd_pkg::ERR_ESCAPE;
                            phase_next  = upd_pkg::PH_PLAIN;
                        end
                        else
                        begin
                            phase_next = upd_pkg::PH_HI;
                        end
                    end
                    default:
                    begin
                        phase_next = upd_pkg::PH_PLAIN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= upd_pkg::PH_PLAIN;
            sticky_reg  <= upd_pkg::ERR_NONE;
            seq_len_reg <= '0;
            oct_cnt_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sticky_reg  <= sticky_next;
            seq_len_reg <= seq_len_next;
            oct_cnt_reg <= oct_cnt_next;
        end
    end

    // Octet and digit holding registers are only read after being written.
    always_ff @(posedge clk)
    begin
        high_nibble_reg <= high_nibble_next;
        held_hex_reg    <= held_hex_next;
        buf_reg         <= buf_next;
    end

endmodule

// File: src/upd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_queue: command queue between front and back
// A small first-in first-out store of decoded commands with a show-ahead head.
// ----------------------------------------------------------------------------
module upd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  upd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output upd_pkg::cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop) count_next = count_reg + CW'(1);
        else if (do_pop && !do_push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: src/upd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_back: result serializer and output register
// Loads the head units into the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module upd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  upd_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   out_unit,
    output logic          string_end,
    output logic [1:0]    error_code,
    output logic          out_last
);

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic [15:0] unit_reg;
    logic        end_reg;
    logic [1:0]  err_reg;
    logic        last_reg;
    logic        load;
    logic        take;
    logic        is_last;

    assign load    = !valid_reg || out_ready;
    assign take    = load && !empty;
    assign is_last = (idx_reg == head.count_m1);
    assign pop     = take && is_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) valid_next = !empty;
        if (take) idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            unit_reg <= head.units[idx_reg];
            end_reg  <= head.string_end;
            err_reg  <= head.error_code;
            last_reg <= is_last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_unit   = unit_reg;
    assign string_end = end_reg;
    assign error_code = err_reg;
    assign out_last   = last_reg;

endmodule

// File: src/upd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upd_checker: port-level checks of the URI percent decoder
// Watches the stream ports and flags results that break the decoder's rules.
// ----------------------------------------------------------------------------
module upd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // The closing result is alone for its transfer and carries no unit.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 16'h0000)
        else $error("closing result malformed");

    // Only the closing result reports an error, and only a known code.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3
            && (m_axis_tuser[0] || m_axis_tuser[2:1] == 2'd0))
        else $error("error code on a plain result");

    // Out of reset the block is empty and ready.
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("block not clear after reset");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
